// File: src/tlsq_pkg.sv
// Shared types, codes and lamp patterns for the traffic light sequencer.
`timescale 1ns / 1ps

package tlsq_pkg;

	localparam int unsigned CLOCK_W = 17;
	localparam int unsigned CFG_DATA_W = 17;
	localparam int unsigned CFG_INDEX_W = 2;

	localparam logic [CLOCK_W-1:0] LAST_SECOND = 17'd86399;
	localparam logic [CLOCK_W-1:0] CLOCK_RESET = 17'd43200;
	localparam logic [CLOCK_W-1:0] START_RESET = 17'd21600;
	localparam logic [CLOCK_W-1:0] END_RESET = 17'd64800;
	localparam logic [3:0] GREEN_LIMIT_RESET = 4'd8;
	localparam logic [3:0] GREEN_COUNT_MAX = 4'd15;

	localparam logic [7:0] AMBER_MASK = 8'h22;

	localparam logic [2:0] MAIN_P1 = 3'd1;
	localparam logic [2:0] MAIN_P2 = 3'd2;
	localparam logic [2:0] MAIN_P3 = 3'd3;
	localparam logic [2:0] MAIN_P4 = 3'd4;
	localparam logic [2:0] MAIN_P5 = 3'd5;
	localparam logic [2:0] MAIN_P6 = 3'd6;

	localparam logic [1:0] TRAIN_P1 = 2'd1;
	localparam logic [1:0] TRAIN_P2 = 2'd2;
	localparam logic [1:0] TRAIN_P3 = 2'd3;

	typedef enum logic [2:0] {
		KIND_TICK = 3'd0,
		KIND_BUTTONS = 3'd1,
		KIND_MANUAL_ON = 3'd2,
		KIND_MANUAL_OFF = 3'd3,
		KIND_STEP = 3'd4,
		KIND_SET_CLOCK = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		CFG_START_TIME = 2'd0,
		CFG_END_TIME = 2'd1,
		CFG_GREEN_LIMIT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [16:0] time_value;
		logic train_off_switch;
		logic train_on_switch;
		logic vehicle_sense_two;
		logic vehicle_sense_one;
		logic ped_button_two;
		logic ped_button_one;
		logic [2:0] kind;
	} in_item_t;

	typedef struct packed {
		logic [16:0] clock_now;
		logic in_window;
		logic [2:0] phase_now;
		logic [7:0] lamps;
	} out_item_t;

	// Lamp bits R1,A1,G1,P1,R2,A2,G2,P2 from bit 0 upward.
	function automatic logic [7:0] phase_lamps(input logic [2:0] phase);
		logic [7:0] lamps;
		case (phase)
			MAIN_P1: lamps = 8'h13;
			MAIN_P2: lamps = 8'h94;
			MAIN_P3: lamps = 8'h12;
			MAIN_P4: lamps = 8'h31;
			MAIN_P5: lamps = 8'h49;
			MAIN_P6: lamps = 8'h21;
			default: lamps = 8'h00;
		endcase
		return lamps;
	endfunction

endpackage

// File: src/traffic_light_sequencer.sv
// Top level of the two-road traffic light sequencer with its time-of-day clock.
// Requests arrive on in_valid/in_ready with an in_item_t payload: second ticks,
// button and detector samples, manual mode commands and clock settings.
// Every accepted request produces exactly one result on out_valid/out_ready:
// the lamps, the main phase, the window flag and the clock after that request.
// A result is registered and appears in the cycle after its request is accepted, and a new
// request can be taken in every cycle while the receiver takes each result; the throughput of
// one request per cycle is set by the single result register that holds the next-state outcome.
// The result register only blocks intake while it holds a result that the
// receiver has not taken; a stalled receiver holds the result unchanged and
// in_ready stays low until out_ready is seen.
// Configuration writes use cfg_valid/cfg_ready, cfg_index and cfg_data and are
// always taken; they are meant to happen only while no request is in flight.
// Index 0 sets the window start, 1 the window end, 2 the green limit; other
// indexes are ignored.
// Asynchronous reset puts the clock at noon, the main phase at one, the train
// phase at three, all lamps off and the window at its default hours.
`timescale 1ns / 1ps

module traffic_light_sequencer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input tlsq_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output tlsq_pkg::out_item_t out_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [tlsq_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [tlsq_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [16:0] start_time_q, end_time_q;
	logic [3:0] green_limit_q;
	logic [16:0] clock_q, clock_d;
	logic [2:0] main_phase_q, main_phase_d;
	logic [1:0] train_phase_q, train_phase_d;
	logic [3:0] green_count_q, green_count_d;
	logic ped_one_q, ped_one_d, ped_two_q, ped_two_d;
	logic det_one_q, det_one_d, det_two_q, det_two_d;
	logic train_mode_q, train_mode_d;
	logic manual_mode_q, manual_mode_d;
	logic step_q, step_d;
	logic [7:0] lamp_q, lamp_d;
	logic win_hit;
	logic accept;
	logic out_valid_q;
	tlsq_pkg::out_item_t out_item_q;
	logic [4:0] green_next;
	logic green_end_one, green_end_two;

	function automatic logic window_test(input logic [16:0] now, input logic [16:0] start_t,
			input logic [16:0] end_t);
		logic hit;
		if (start_t < end_t) begin
			hit = (now > start_t) && (now < end_t);
		end else begin
			hit = (now > start_t) || (now < end_t);
		end
		return hit;
	endfunction

	assign accept = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	assign green_next = {1'b0, green_count_q} + 5'd1;
	assign green_end_one = (green_next > {1'b0, green_limit_q}) || ped_one_q
		|| (det_two_q && !det_one_q && !ped_two_q);
	assign green_end_two = (green_next > {1'b0, green_limit_q}) || ped_two_q
		|| (det_one_q && !det_two_q && !ped_one_q);

	always_comb begin
		clock_d = clock_q;
		main_phase_d = main_phase_q;
		train_phase_d = train_phase_q;
		green_count_d = green_count_q;
		ped_one_d = ped_one_q;
		ped_two_d = ped_two_q;
		det_one_d = det_one_q;
		det_two_d = det_two_q;
		train_mode_d = train_mode_q;
		manual_mode_d = manual_mode_q;
		step_d = step_q;
		lamp_d = lamp_q;
		win_hit = 1'b0;
		case (tlsq_pkg::kind_t'(in_item.kind))
			tlsq_pkg::KIND_TICK: begin
				clock_d = (clock_q == tlsq_pkg::LAST_SECOND) ? '0 : clock_q + 17'd1;
				win_hit = window_test(clock_d, start_time_q, end_time_q);
				if (manual_mode_q) begin
					if (!train_mode_q && main_phase_q >= tlsq_pkg::MAIN_P1
							&& main_phase_q <= tlsq_pkg::MAIN_P6) begin
						lamp_d = tlsq_pkg::phase_lamps(main_phase_q);
						if (step_q) begin
							main_phase_d = (main_phase_q == tlsq_pkg::MAIN_P6) ?
								tlsq_pkg::MAIN_P1 : main_phase_q + 3'd1;
							step_d = 1'b0;
						end
					end
				end else if (!win_hit) begin
					lamp_d = (lamp_q & tlsq_pkg::AMBER_MASK) ^ tlsq_pkg::AMBER_MASK;
				end else if (train_mode_q) begin
					case (train_phase_q)
						tlsq_pkg::TRAIN_P1: begin
							lamp_d = tlsq_pkg::phase_lamps(tlsq_pkg::MAIN_P1);
							train_phase_d = tlsq_pkg::TRAIN_P2;
							main_phase_d = tlsq_pkg::MAIN_P2;
							ped_one_d = 1'b0;
							ped_two_d = 1'b0;
							det_one_d = 1'b0;
							det_two_d = 1'b0;
						end
						tlsq_pkg::TRAIN_P2: begin
							lamp_d = tlsq_pkg::phase_lamps(tlsq_pkg::MAIN_P2);
							main_phase_d = tlsq_pkg::MAIN_P3;
						end
						tlsq_pkg::TRAIN_P3: begin
							lamp_d = tlsq_pkg::phase_lamps(tlsq_pkg::MAIN_P6);
							train_phase_d = tlsq_pkg::TRAIN_P1;
							main_phase_d = tlsq_pkg::MAIN_P1;
						end
						default: begin
						end
					endcase
				end else begin
					if (main_phase_q >= tlsq_pkg::MAIN_P1
							&& main_phase_q <= tlsq_pkg::MAIN_P6) begin
						lamp_d = tlsq_pkg::phase_lamps(main_phase_q);
					end
					case (main_phase_q)
						tlsq_pkg::MAIN_P1, tlsq_pkg::MAIN_P4: begin
							green_count_d = '0;
							main_phase_d = main_phase_q + 3'd1;
							train_phase_d = (main_phase_q == tlsq_pkg::MAIN_P1) ?
								tlsq_pkg::TRAIN_P2 : tlsq_pkg::TRAIN_P3;
							ped_one_d = 1'b0;
							ped_two_d = 1'b0;
							det_one_d = 1'b0;
							det_two_d = 1'b0;
						end
						tlsq_pkg::MAIN_P2, tlsq_pkg::MAIN_P5: begin
							green_count_d = green_next[4] ? tlsq_pkg::GREEN_COUNT_MAX
								: green_next[3:0];
							if (main_phase_q == tlsq_pkg::MAIN_P2 && green_end_one) begin
								main_phase_d = tlsq_pkg::MAIN_P3;
								train_phase_d = tlsq_pkg::TRAIN_P2;
							end
							if (main_phase_q == tlsq_pkg::MAIN_P5 && green_end_two) begin
								main_phase_d = tlsq_pkg::MAIN_P6;
								train_phase_d = tlsq_pkg::TRAIN_P3;
							end
						end
						tlsq_pkg::MAIN_P3: begin
							main_phase_d = tlsq_pkg::MAIN_P4;
							train_phase_d = tlsq_pkg::TRAIN_P3;
						end
						tlsq_pkg::MAIN_P6: begin
							main_phase_d = tlsq_pkg::MAIN_P1;
							train_phase_d = tlsq_pkg::TRAIN_P1;
						end
						default: begin
						end
					endcase
				end
			end
			tlsq_pkg::KIND_BUTTONS: begin
				ped_one_d = ped_one_q | in_item.ped_button_one;
				ped_two_d = ped_two_q | in_item.ped_button_two;
				det_one_d = det_one_q | in_item.vehicle_sense_one;
				det_two_d = det_two_q | in_item.vehicle_sense_two;
				if (in_item.train_on_switch) begin
					train_mode_d = 1'b1;
					main_phase_d = tlsq_pkg::MAIN_P6;
				end
				if (in_item.train_off_switch) begin
					train_mode_d = 1'b0;
				end
			end
			tlsq_pkg::KIND_MANUAL_ON: begin
				if (!manual_mode_q) begin
					manual_mode_d = 1'b1;
					main_phase_d = tlsq_pkg::MAIN_P1;
				end
			end
			tlsq_pkg::KIND_MANUAL_OFF: begin
				manual_mode_d = 1'b0;
			end
			tlsq_pkg::KIND_STEP: begin
				if (manual_mode_q) begin
					step_d = 1'b1;
				end
			end
			tlsq_pkg::KIND_SET_CLOCK: begin
				if (in_item.time_value <= tlsq_pkg::LAST_SECOND) begin
					clock_d = in_item.time_value;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= tlsq_pkg::START_RESET;
			end_time_q <= tlsq_pkg::END_RESET;
			green_limit_q <= tlsq_pkg::GREEN_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (tlsq_pkg::cfg_reg_t'(cfg_index))
				tlsq_pkg::CFG_START_TIME: start_time_q <= cfg_data[16:0];
				tlsq_pkg::CFG_END_TIME: end_time_q <= cfg_data[16:0];
				tlsq_pkg::CFG_GREEN_LIMIT: green_limit_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= tlsq_pkg::CLOCK_RESET;
			main_phase_q <= tlsq_pkg::MAIN_P1;
			train_phase_q <= tlsq_pkg::TRAIN_P3;
			green_count_q <= '0;
			ped_one_q <= 1'b0;
			ped_two_q <= 1'b0;
			det_one_q <= 1'b0;
			det_two_q <= 1'b0;
			train_mode_q <= 1'b0;
			manual_mode_q <= 1'b0;
			step_q <= 1'b0;
			lamp_q <= '0;
		end else if (accept) begin
			clock_q <= clock_d;
			main_phase_q <= main_phase_d;
			train_phase_q <= train_phase_d;
			green_count_q <= green_count_d;
			ped_one_q <= ped_one_d;
			ped_two_q <= ped_two_d;
			det_one_q <= det_one_d;
			det_two_q <= det_two_d;
			train_mode_q <= train_mode_d;
			manual_mode_q <= manual_mode_d;
			step_q <= step_d;
			lamp_q <= lamp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_item_q.lamps <= lamp_d;
			out_item_q.phase_now <= main_phase_d;
			out_item_q.in_window <= window_test(clock_d, start_time_q, end_time_q);
			out_item_q.clock_now <= clock_d;
		end
	end

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("Accepted request did not produce a result.");

	a_clock_range: assert property (@(posedge clk) disable iff (!arst_n)
		clock_q <= tlsq_pkg::LAST_SECOND)
		else $error("Time of day left its range.");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		main_phase_q >= tlsq_pkg::MAIN_P1 && main_phase_q <= tlsq_pkg::MAIN_P6)
		else $error("Main phase left its range.");

	a_train_phase: assert property (@(posedge clk) disable iff (!arst_n)
		train_phase_q != 2'd0)
		else $error("Train phase became zero.");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (out_item_q.clock_now == clock_q && out_item_q.lamps == lamp_q))
		else $error("Result does not match the updated state.");

endmodule

// File: dv/tlsq_checker.sv
// Checker that predicts and compares every result of the traffic light sequencer.
`timescale 1ns / 1ps

module tlsq_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input tlsq_pkg::in_item_t in_item,
	input logic out_valid,
	input logic out_ready,
	input tlsq_pkg::out_item_t out_item,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [tlsq_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [tlsq_pkg::CFG_DATA_W-1:0] cfg_data,
	output int mismatches,
	output int outstanding
);

	// Lamp pattern of each main phase, phase 0 in the low byte.
	localparam logic [63:0] LIGHTS_BY_PHASE =
		{8'h00, 8'h21, 8'h49, 8'h31, 8'h12, 8'h94, 8'h13, 8'h00};

	logic [16:0] win_start = tlsq_pkg::START_RESET;
	logic [16:0] win_end = tlsq_pkg::END_RESET;
	logic [3:0] green_lim = tlsq_pkg::GREEN_LIMIT_RESET;

	logic [16:0] tod = tlsq_pkg::CLOCK_RESET;
	logic [2:0] phase_m = tlsq_pkg::MAIN_P1;
	logic [1:0] phase_t = tlsq_pkg::TRAIN_P3;
	logic [3:0] green_cnt = '0;
	logic ped_one = 1'b0;
	logic ped_two = 1'b0;
	logic det_one = 1'b0;
	logic det_two = 1'b0;
	logic train_on = 1'b0;
	logic manual_on = 1'b0;
	logic step_pend = 1'b0;
	logic [7:0] lights = '0;

	tlsq_pkg::out_item_t expected_lights [$];
	tlsq_pkg::out_item_t want;
	int fail_total = 0;
	int in_flight = 0;

	assign mismatches = fail_total;
	assign outstanding = in_flight;

	function automatic logic window_open();
		if (win_start < win_end)
			return (win_start < tod) && (tod < win_end);
		return (tod > win_start) || (tod < win_end);
	endfunction

	function automatic void drop_latches();
		ped_one = 1'b0;
		ped_two = 1'b0;
		det_one = 1'b0;
		det_two = 1'b0;
	endfunction

	function automatic void toggle_ambers();
		lights = (lights & tlsq_pkg::AMBER_MASK) ^ tlsq_pkg::AMBER_MASK;
	endfunction

	function automatic logic green_expired(input logic own_ped, input logic other_ped,
			input logic own_det, input logic other_det);
		logic [4:0] next_cnt;
		next_cnt = {1'b0, green_cnt} + 5'd1;
		green_cnt = (next_cnt > 5'd15) ? tlsq_pkg::GREEN_COUNT_MAX : next_cnt[3:0];
		return (next_cnt > {1'b0, green_lim}) || own_ped
			|| (other_det && !own_det && !other_ped);
	endfunction

	function automatic void run_main(input logic win_now);
		if (manual_on) begin
			if (phase_m >= tlsq_pkg::MAIN_P1 && phase_m <= tlsq_pkg::MAIN_P6) begin
				lights = LIGHTS_BY_PHASE[phase_m*8 +: 8];
				if (step_pend) begin
					phase_m = (phase_m == tlsq_pkg::MAIN_P6) ? tlsq_pkg::MAIN_P1
						: phase_m + 3'd1;
					step_pend = 1'b0;
				end
			end
		end else if (!win_now) begin
			toggle_ambers();
		end else if (phase_m >= tlsq_pkg::MAIN_P1 && phase_m <= tlsq_pkg::MAIN_P6) begin
			lights = LIGHTS_BY_PHASE[phase_m*8 +: 8];
			case (phase_m)
				tlsq_pkg::MAIN_P1: begin
					green_cnt = '0;
					phase_m = tlsq_pkg::MAIN_P2;
					phase_t = tlsq_pkg::TRAIN_P2;
					drop_latches();
				end
				tlsq_pkg::MAIN_P2: begin
					if (green_expired(ped_one, ped_two, det_one, det_two)) begin
						phase_m = tlsq_pkg::MAIN_P3;
						phase_t = tlsq_pkg::TRAIN_P2;
					end
				end
				tlsq_pkg::MAIN_P3: begin
					phase_m = tlsq_pkg::MAIN_P4;
					phase_t = tlsq_pkg::TRAIN_P3;
				end
				tlsq_pkg::MAIN_P4: begin
					green_cnt = '0;
					phase_m = tlsq_pkg::MAIN_P5;
					phase_t = tlsq_pkg::TRAIN_P3;
					drop_latches();
				end
				tlsq_pkg::MAIN_P5: begin
					if (green_expired(ped_two, ped_one, det_two, det_one)) begin
						phase_m = tlsq_pkg::MAIN_P6;
						phase_t = tlsq_pkg::TRAIN_P3;
					end
				end
				default: begin
					phase_m = tlsq_pkg::MAIN_P1;
					phase_t = tlsq_pkg::TRAIN_P1;
				end
			endcase
		end
	endfunction

	function automatic void run_train(input logic win_now);
		if (manual_on)
			return;
		if (!win_now) begin
			toggle_ambers();
			return;
		end
		case (phase_t)
			tlsq_pkg::TRAIN_P1: begin
				lights = LIGHTS_BY_PHASE[tlsq_pkg::MAIN_P1*8 +: 8];
				phase_t = tlsq_pkg::TRAIN_P2;
				phase_m = tlsq_pkg::MAIN_P2;
				drop_latches();
			end
			tlsq_pkg::TRAIN_P2: begin
				lights = LIGHTS_BY_PHASE[tlsq_pkg::MAIN_P2*8 +: 8];
				phase_m = tlsq_pkg::MAIN_P3;
			end
			tlsq_pkg::TRAIN_P3: begin
				lights = LIGHTS_BY_PHASE[tlsq_pkg::MAIN_P6*8 +: 8];
				phase_t = tlsq_pkg::TRAIN_P1;
				phase_m = tlsq_pkg::MAIN_P1;
			end
			default: ;
		endcase
	endfunction

	function automatic tlsq_pkg::out_item_t step_lights(input tlsq_pkg::in_item_t req);
		tlsq_pkg::out_item_t res;
		case (req.kind)
			tlsq_pkg::KIND_TICK: begin
				tod = (tod == tlsq_pkg::LAST_SECOND) ? 17'd0 : tod + 17'd1;
				if (train_on)
					run_train(window_open());
				else
					run_main(window_open());
			end
			tlsq_pkg::KIND_BUTTONS: begin
				if (req.ped_button_one) ped_one = 1'b1;
				if (req.ped_button_two) ped_two = 1'b1;
				if (req.vehicle_sense_one) det_one = 1'b1;
				if (req.vehicle_sense_two) det_two = 1'b1;
				if (req.train_on_switch) begin
					train_on = 1'b1;
					phase_m = tlsq_pkg::MAIN_P6;
				end
				if (req.train_off_switch) train_on = 1'b0;
			end
			tlsq_pkg::KIND_MANUAL_ON: begin
				if (!manual_on) begin
					manual_on = 1'b1;
					phase_m = tlsq_pkg::MAIN_P1;
				end
			end
			tlsq_pkg::KIND_MANUAL_OFF: manual_on = 1'b0;
			tlsq_pkg::KIND_STEP: begin
				if (manual_on) step_pend = 1'b1;
			end
			tlsq_pkg::KIND_SET_CLOCK: begin
				if (req.time_value <= tlsq_pkg::LAST_SECOND) tod = req.time_value;
			end
			default: ;
		endcase
		res.lamps = lights;
		res.phase_now = phase_m;
		res.in_window = window_open();
		res.clock_now = tod;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [16:0] got,
			input logic [16:0] exp_val);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, exp_val);
		fail_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start = tlsq_pkg::START_RESET;
			win_end = tlsq_pkg::END_RESET;
			green_lim = tlsq_pkg::GREEN_LIMIT_RESET;
			tod = tlsq_pkg::CLOCK_RESET;
			phase_m = tlsq_pkg::MAIN_P1;
			phase_t = tlsq_pkg::TRAIN_P3;
			green_cnt = '0;
			drop_latches();
			train_on = 1'b0;
			manual_on = 1'b0;
			step_pend = 1'b0;
			lights = '0;
			expected_lights.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tlsq_pkg::CFG_START_TIME: win_start = cfg_data;
					tlsq_pkg::CFG_END_TIME: win_end = cfg_data;
					tlsq_pkg::CFG_GREEN_LIMIT: green_lim = cfg_data[3:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_lights.size() == 0) begin
					report_mismatch("result with no request outstanding, clock",
						out_item.clock_now, 17'd0);
				end else begin
					want = expected_lights.pop_front();
					if (out_item.lamps !== want.lamps)
						report_mismatch("lamps", {9'd0, out_item.lamps},
							{9'd0, want.lamps});
					if (out_item.phase_now !== want.phase_now)
						report_mismatch("phase", {14'd0, out_item.phase_now},
							{14'd0, want.phase_now});
					if (out_item.in_window !== want.in_window)
						report_mismatch("window flag", {16'd0, out_item.in_window},
							{16'd0, want.in_window});
					if (out_item.clock_now !== want.clock_now)
						report_mismatch("clock", out_item.clock_now, want.clock_now);
				end
			end
			if (in_valid && in_ready)
				expected_lights.push_back(step_lights(in_item));
		end
		in_flight = expected_lights.size();
	end

endmodule

// File: dv/tb_top.sv
// Top of the traffic light sequencer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int PHASE_COUNT = 7;
	localparam int ITEMS_PER_PHASE = 210;
	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_STALLS,
		RX_SLOW
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	tlsq_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	tlsq_pkg::out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tlsq_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [tlsq_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	int mismatches;
	int outstanding;

	int unsigned cycle_count = 0;
	int burst_left = 0;
	int cur_start = tlsq_pkg::START_RESET;
	int cur_end = tlsq_pkg::END_RESET;
	rx_mode_t rx_mode = RX_FREE;
	int rx_cycle = 0;
	int stall_left = 0;

	traffic_light_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tlsq_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// The receiver picks a new random stall pattern whenever its mode counter wraps.
	always @(negedge clk) begin
		if (rx_cycle == 0)
			rx_mode = rx_mode_t'($urandom_range(RX_FREE, RX_SLOW));
		rx_cycle = (rx_cycle + 1) % 48;
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE: out_ready <= 1'b1;
				RX_COIN: out_ready <= ($urandom_range(0, 1) == 1);
				RX_STALLS: begin
					if ($urandom_range(0, 7) == 0) begin
						stall_left = $urandom_range(1, 12);
						out_ready <= 1'b0;
					end else begin
						out_ready <= 1'b1;
					end
				end
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Switch bits are {train off, train on, vehicle two, vehicle one, ped two, ped one}.
	function automatic tlsq_pkg::in_item_t item_of(input logic [2:0] kind,
			input logic [5:0] switches, input logic [16:0] tv);
		tlsq_pkg::in_item_t req;
		req.kind = kind;
		{req.train_off_switch, req.train_on_switch, req.vehicle_sense_two,
			req.vehicle_sense_one, req.ped_button_two, req.ped_button_one} = switches;
		req.time_value = tv;
		return req;
	endfunction

	function automatic tlsq_pkg::in_item_t random_item();
		tlsq_pkg::in_item_t req;
		int pick;
		int tv;
		req.time_value = 17'($urandom_range(0, 17'h1FFFF));
		req.ped_button_one = ($urandom_range(0, 3) == 0);
		req.ped_button_two = ($urandom_range(0, 3) == 0);
		req.vehicle_sense_one = ($urandom_range(0, 99) < 35);
		req.vehicle_sense_two = ($urandom_range(0, 99) < 35);
		req.train_on_switch = ($urandom_range(0, 99) < 5);
		req.train_off_switch = ($urandom_range(0, 99) < 12);
		pick = $urandom_range(0, 99);
		if (pick < 60)
			req.kind = tlsq_pkg::KIND_TICK;
		else if (pick < 78)
			req.kind = tlsq_pkg::KIND_BUTTONS;
		else if (pick < 79)
			req.kind = tlsq_pkg::KIND_MANUAL_ON;
		else if (pick < 84)
			req.kind = tlsq_pkg::KIND_MANUAL_OFF;
		else if (pick < 89)
			req.kind = tlsq_pkg::KIND_STEP;
		else if (pick < 97) begin
			req.kind = tlsq_pkg::KIND_SET_CLOCK;
			case ($urandom_range(0, 5))
				0: tv = $urandom_range(0, 17'h1FFFF);
				1: tv = $urandom_range(0, tlsq_pkg::LAST_SECOND);
				2: tv = cur_start + $urandom_range(0, 6) - 3;
				3: tv = cur_end + $urandom_range(0, 6) - 3;
				4: tv = $urandom_range(tlsq_pkg::LAST_SECOND - 3, tlsq_pkg::LAST_SECOND);
				default: tv = $urandom_range(tlsq_pkg::LAST_SECOND + 1, 17'h1FFFF);
			endcase
			if (tv < 0)
				tv += tlsq_pkg::LAST_SECOND + 1;
			else if (tv > 17'h1FFFF)
				tv -= tlsq_pkg::LAST_SECOND + 1;
			req.time_value = 17'(tv);
		end else if (pick < 98)
			req.kind = KIND_SPARE_LO;
		else if (pick < 99)
			req.kind = KIND_SPARE_HI;
		else
			req.kind = tlsq_pkg::KIND_TICK;
		return req;
	endfunction

	// Requests go out in bursts; valid stays high between requests of one burst.
	task automatic push_request(input tlsq_pkg::in_item_t req);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
	endtask

	task automatic drain_requests();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input tlsq_pkg::cfg_reg_t idx, input logic [16:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic write_config(input int start_s, input int end_s, input int limit);
		write_reg(tlsq_pkg::CFG_START_TIME, 17'(start_s));
		write_reg(tlsq_pkg::CFG_END_TIME, 17'(end_s));
		write_reg(tlsq_pkg::CFG_GREEN_LIMIT, 17'(limit));
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_start = start_s;
		cur_end = end_s;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_request(item_of(tlsq_pkg::KIND_TICK, 6'b000000, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_BUTTONS, 6'b001111, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_TICK, 6'b000000, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_BUTTONS, 6'b110000, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_BUTTONS, 6'b010000, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_TICK, 6'b000000, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_BUTTONS, 6'b100000, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_STEP, 6'b000000, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_MANUAL_ON, 6'b000000, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_MANUAL_ON, 6'b000000, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_STEP, 6'b000000, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_TICK, 6'b000000, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_MANUAL_OFF, 6'b000000, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_MANUAL_OFF, 6'b000000, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_SET_CLOCK, 6'b000000, tlsq_pkg::LAST_SECOND));
		push_request(item_of(tlsq_pkg::KIND_TICK, 6'b000000, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_TICK, 6'b000000, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_SET_CLOCK, 6'b000000,
			tlsq_pkg::LAST_SECOND + 17'd1));
		push_request(item_of(tlsq_pkg::KIND_SET_CLOCK, 6'b111111, 17'h1FFFF));
		push_request(item_of(KIND_SPARE_LO, 6'b111111, 17'h1FFFF));
		push_request(item_of(KIND_SPARE_HI, 6'b111111, 17'h1FFFF));
		push_request(item_of(tlsq_pkg::KIND_SET_CLOCK, 6'b000000, tlsq_pkg::START_RESET));
		push_request(item_of(tlsq_pkg::KIND_TICK, 6'b000000, 17'd0));
		push_request(item_of(tlsq_pkg::KIND_SET_CLOCK, 6'b000000,
			tlsq_pkg::END_RESET - 17'd1));
		push_request(item_of(tlsq_pkg::KIND_TICK, 6'b000000, 17'd0));

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			drain_requests();
			case (ph)
				0: write_config(0, tlsq_pkg::LAST_SECOND, 15);
				1: write_config(tlsq_pkg::LAST_SECOND, 0, 1);
				2: write_config(72000, 21600, 3);
				3: write_config(0, 0, 15);
				4: write_config(100, 86000, 1);
				5: write_config(tlsq_pkg::START_RESET, tlsq_pkg::END_RESET,
					tlsq_pkg::GREEN_LIMIT_RESET);
				default: write_config($urandom_range(0, tlsq_pkg::LAST_SECOND),
					$urandom_range(0, tlsq_pkg::LAST_SECOND), $urandom_range(1, 15));
			endcase
			repeat (ITEMS_PER_PHASE) push_request(random_item());
		end
		drain_requests();

		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
